// ===== hdl/stbs_pkg.sv =====
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int KEY_W       = 32;
	// one probe per halving level: a span of TABLE_DEPTH entries needs IDX_W + 1 probes
	localparam int LEVELS      = IDX_W + 1;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

	typedef struct packed {
		logic                    func;
		logic [IDX_W-1:0]        entry_index;
		logic signed [KEY_W-1:0] entry_value;
		logic signed [KEY_W-1:0] search_key;
	} in_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
	} out_t;

	// one item in flight; data is the write value or the search key
	typedef struct packed {
		logic                    func;
		logic [IDX_W-1:0]        idx;
		logic signed [KEY_W-1:0] data;
		logic [IDX_W-1:0]        lo;
		logic [IDX_W-1:0]        hi;
		logic                    done;
		logic                    found;
	} stage_t;

endpackage

// ===== hdl/stbs_ram.sv =====
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/stbs_probe.sv =====
module stbs_probe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            prev_valid,
	input  stbs_pkg::stage_t prev,
	output logic            next_valid,
	output stbs_pkg::stage_t next
);

	logic [stbs_pkg::IDX_W:0]        span_sum;
	logic [stbs_pkg::IDX_W-1:0]      mid;
	logic                            we;
	logic [stbs_pkg::KEY_W-1:0]      rd;
	logic                            vld_s1;
	stbs_pkg::stage_t                cur_s1;
	logic [stbs_pkg::IDX_W-1:0]      mid_s1;
	stbs_pkg::stage_t                upd;

	assign span_sum = {1'b0, prev.lo} + {1'b0, prev.hi};
	assign mid      = span_sum[stbs_pkg::IDX_W:1];

	// this level's table copy sees writes in item order
	assign we = adv && prev_valid && (prev.func == stbs_pkg::FUNC_WRITE);

	stbs_ram #(
		.WIDTH(stbs_pkg::KEY_W),
		.DEPTH(stbs_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(prev.idx),
		.wdata(prev.data),
		.re   (adv),
		.raddr(mid),
		.rdata(rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s1 <= prev;
			mid_s1 <= mid;
		end
	end

	// on a match park the position in lo; an empty span ends the search
	always_comb begin
		upd = cur_s1;
		if (cur_s1.func == stbs_pkg::FUNC_SEARCH && !cur_s1.done) begin
			if ($signed(rd) == cur_s1.data) begin
				upd.found = 1'b1;
				upd.done  = 1'b1;
				upd.lo    = mid_s1;
			end else if ($signed(rd) > cur_s1.data) begin
				if (mid_s1 == cur_s1.lo) begin
					upd.done = 1'b1;
				end else begin
					upd.hi = mid_s1 - stbs_pkg::IDX_ONE;
				end
			end else begin
				if (mid_s1 == cur_s1.hi) begin
					upd.done = 1'b1;
				end else begin
					upd.lo = mid_s1 + stbs_pkg::IDX_ONE;
				end
			end
		end
	end

	assign next_valid = vld_s1;
	assign next       = upd;

endmodule

// ===== hdl/sorted_table_binary_search_top.sv =====
// Binary search over a sorted table of up to 1024 signed 32-bit entries. A write beat
// (func 0) stores one entry and returns nothing; a search beat (func 1) returns one beat
// with found and position (position 0 when not found). The block takes one beat per
// cycle while no result beat is held, and passes each search through a register stage for
// the range check against the first and last entry in use, then one pipeline stage per
// halving level (11 levels), each with its own copy of the table, then the output
// register. Writes travel down the same pipeline and update each copy as they pass, so
// every search sees exactly the writes accepted before it. When a result beat is held
// by out_ready low the whole pipeline holds and in_ready drops. entries_in_use is set
// through cfg_wr_en/cfg_wr_data; the user must do so only while the block is idle, which
// the block does not enforce. 0 counts as 1 and values above 1024 count as 1024.
module sorted_table_binary_search_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [stbs_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  stbs_pkg::in_t             in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output stbs_pkg::out_t            out_data
);

	logic                            adv;
	logic                            accept;
	logic [stbs_pkg::IDX_W-1:0]      hi_lim_q;
	logic [stbs_pkg::CNT_W-1:0]      cfg_m1;
	logic signed [stbs_pkg::KEY_W-1:0] entry0_q;
	logic                            bound_we;
	logic [stbs_pkg::KEY_W-1:0]      bound_rd;
	logic                            vld_s1;
	stbs_pkg::stage_t                st_s1;
	logic signed [stbs_pkg::KEY_W-1:0] e0_s1;
	logic                            out_of_range;
	logic                            lvl_v [stbs_pkg::LEVELS+1];
	stbs_pkg::stage_t                lvl   [stbs_pkg::LEVELS+1];
	logic                            out_valid_q;
	stbs_pkg::out_t                  out_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && in_ready;

	// keep the last index in use, already clamped to the table
	assign cfg_m1 = cfg_wr_data - stbs_pkg::CNT_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_lim_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data == '0) begin
				hi_lim_q <= '0;
			end else if (cfg_wr_data > stbs_pkg::CNT_FULL) begin
				hi_lim_q <= stbs_pkg::IDX_LAST;
			end else begin
				hi_lim_q <= cfg_m1[stbs_pkg::IDX_W-1:0];
			end
		end
	end

	assign bound_we = accept && (in_data.func == stbs_pkg::FUNC_WRITE);

	always_ff @(posedge clk) begin
		if (bound_we && in_data.entry_index == '0) begin
			entry0_q <= in_data.entry_value;
		end
	end

	// copy used for the upper bound: read at the last index in use
	stbs_ram #(
		.WIDTH(stbs_pkg::KEY_W),
		.DEPTH(stbs_pkg::TABLE_DEPTH)
	) u_bound_ram (
		.clk  (clk),
		.we   (bound_we),
		.waddr(in_data.entry_index),
		.wdata(in_data.entry_value),
		.re   (adv),
		.raddr(hi_lim_q),
		.rdata(bound_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1.func  <= in_data.func;
			st_s1.idx   <= in_data.entry_index;
			st_s1.data  <= (in_data.func == stbs_pkg::FUNC_WRITE) ?
				in_data.entry_value : in_data.search_key;
			st_s1.lo    <= '0;
			st_s1.hi    <= hi_lim_q;
			st_s1.done  <= 1'b0;
			st_s1.found <= 1'b0;
			e0_s1       <= entry0_q;
		end
	end

	assign out_of_range = (st_s1.data < e0_s1) || (st_s1.data > $signed(bound_rd));

	always_comb begin
		lvl[0]      = st_s1;
		lvl[0].done = out_of_range;
		lvl_v[0]    = vld_s1;
	end

	for (genvar g = 0; g < stbs_pkg::LEVELS; g++) begin : g_level
		stbs_probe u_probe (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.prev_valid(lvl_v[g]),
			.prev      (lvl[g]),
			.next_valid(lvl_v[g+1]),
			.next      (lvl[g+1])
		);
	end

	// drop write beats here; they produce no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= lvl_v[stbs_pkg::LEVELS] &&
				(lvl[stbs_pkg::LEVELS].func == stbs_pkg::FUNC_SEARCH);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.found    <= lvl[stbs_pkg::LEVELS].found;
			out_q.position <= lvl[stbs_pkg::LEVELS].found ? lvl[stbs_pkg::LEVELS].lo : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_search_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_v[stbs_pkg::LEVELS] && lvl[stbs_pkg::LEVELS].func == stbs_pkg::FUNC_SEARCH
		|-> lvl[stbs_pkg::LEVELS].done)
		else $error("search left the last level unfinished");

	a_miss_position_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.position == '0)
		else $error("miss result carries a nonzero position");

	a_search_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && lvl_v[stbs_pkg::LEVELS] &&
		lvl[stbs_pkg::LEVELS].func == stbs_pkg::FUNC_SEARCH |=> out_valid)
		else $error("search beat lost at the output register");

endmodule

// ===== tb/tb_sorted_table_binary_search_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_top;

	import stbs_pkg::*;

	typedef enum {PACE_STEADY, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;
	typedef enum {STEP_WRITE, STEP_SEARCH, STEP_COUNT} step_e;

	typedef struct {
		step_e                   kind;
		int                      idx;
		logic signed [KEY_W-1:0] val;
		bit                      typed;
		out_t                    want;
	} row_t;

	localparam logic signed [KEY_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
	localparam longint LOW_END  = -64'sd2147483648;
	localparam longint HIGH_END = 64'sd2147483647;
	localparam int     SETTLE_CYCLES = 20;
	localparam int     HOLD_CYCLES   = 200;
	localparam int     ITEMS_PER_PHASE = 42;
	localparam logic [CNT_W-1:0] COUNT_PLAN [12] =
		'{11'd0, 11'd1, 11'd2, 11'd3, 11'd5, 11'd16, 11'd37, 11'd100, 11'd513, 11'd1024,
		  11'd2047, 11'd1025};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;

	sorted_table_binary_search_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb_sorted_table_binary_search_top: FAIL");
		$finish;
	end

	// shadow of the block: table contents and effective entry count
	logic signed [KEY_W-1:0] entry_copy [TABLE_DEPTH];
	int    covered = 1;
	int    written_prefix = 0;
	out_t  search_results_due [$];
	int    bad_beats = 0;
	pace_e pace = PACE_STEADY;
	int    hold_requests = 0;
	int    hold_seen = 0;
	int    hold_left = 0;

	function automatic out_t predict_search(logic signed [KEY_W-1:0] key);
		int   lo;
		int   hi;
		int   mid;
		out_t res;
		res = '0;
		lo = 0;
		hi = covered - 1;
		if (key < entry_copy[0] || key > entry_copy[hi])
			return res;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (entry_copy[mid] == key) begin
				res.found = 1'b1;
				res.position = IDX_W'(mid);
				return res;
			end
			if (entry_copy[mid] > key)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return res;
	endfunction

	function automatic in_t make_beat(logic func, int idx, logic signed [KEY_W-1:0] val);
		in_t b;
		b.func = func;
		b.entry_index = IDX_W'(idx);
		b.entry_value = (func == FUNC_WRITE) ? val : $urandom();
		b.search_key = (func == FUNC_SEARCH) ? val : $urandom();
		return b;
	endfunction

	function automatic row_t plan_row(step_e kind, int idx, logic signed [KEY_W-1:0] val,
			bit typed = 1'b0, logic f = 1'b0, int pos = 0);
		row_t r;
		r.kind = kind;
		r.idx = idx;
		r.val = val;
		r.typed = typed;
		r.want.found = f;
		r.want.position = IDX_W'(pos);
		return r;
	endfunction

	// call at a rising edge; returns at the edge where the beat is taken
	task automatic send_beat(input in_t b, input bit typed, input out_t typed_want);
		int tx_pct;
		tx_pct = (pace == PACE_SENDER) ? 86 : (pace == PACE_BOTH) ? 29 : 0;
		while ($urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do
			@(posedge clk);
		while (!in_ready);
		if (b.func == FUNC_WRITE)
			entry_copy[b.entry_index] = b.entry_value;
		else
			search_results_due.push_back(typed ? typed_want : predict_search(b.search_key));
	endtask

	// drain: no beat offered, every result back, writes out of the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		while (search_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] n);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		covered = (n == 0) ? 1 : (n > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
	endtask

	always @(posedge clk) begin
		out_t want;
		int   rx_pct;
		if (arst_n && out_valid && out_ready) begin
			if (search_results_due.size() == 0) begin
				if (bad_beats < 10)
					$display("unexpected result beat: found %0b position %0d",
						out_data.found, out_data.position);
				bad_beats++;
			end else begin
				want = search_results_due.pop_front();
				if (out_data.found !== want.found || out_data.position !== want.position) begin
					if (bad_beats < 10)
						$display("result mismatch: expected found %0b position %0d, got found %0b position %0d",
							want.found, want.position, out_data.found, out_data.position);
					bad_beats++;
				end
			end
		end
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		rx_pct = (pace == PACE_RECEIVER) ? 86 : (pace == PACE_BOTH) ? 29 : 0;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_pct);
		end
	end

	initial begin
		row_t   plan [$];
		int     p;
		int     i;
		int     j;
		int     k;
		int     r;
		int     s;
		longint lo_l;
		longint hi_l;
		longint ramp;
		longint unsigned width;
		logic signed [KEY_W-1:0] v;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one entry in use after reset
		plan.push_back(plan_row(STEP_WRITE, 0, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, 0, 1'b1, 1'b1, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, 1, 1'b1, 1'b0, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, -1, 1'b1, 1'b0, 0));
		plan.push_back(plan_row(STEP_WRITE, 0, VALUE_MIN));
		plan.push_back(plan_row(STEP_SEARCH, 0, VALUE_MIN, 1'b1, 1'b1, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, VALUE_MAX, 1'b1, 1'b0, 0));
		plan.push_back(plan_row(STEP_WRITE, 0, VALUE_MAX));
		plan.push_back(plan_row(STEP_SEARCH, 0, VALUE_MAX, 1'b1, 1'b1, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, VALUE_MIN, 1'b1, 1'b0, 0));
		// writes outside the searched span
		plan.push_back(plan_row(STEP_WRITE, TABLE_DEPTH - 1, VALUE_MIN));
		plan.push_back(plan_row(STEP_WRITE, TABLE_DEPTH - 1, VALUE_MAX));
		plan.push_back(plan_row(STEP_WRITE, 682, 32'sh5555_5555));
		plan.push_back(plan_row(STEP_WRITE, 341, 32'sh2aaa_aaaa));
		// a count of zero acts as one
		plan.push_back(plan_row(STEP_COUNT, 0, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, VALUE_MAX, 1'b1, 1'b1, 0));
		plan.push_back(plan_row(STEP_WRITE, 0, -10));
		plan.push_back(plan_row(STEP_WRITE, 1, 10));
		plan.push_back(plan_row(STEP_COUNT, 0, 2));
		plan.push_back(plan_row(STEP_SEARCH, 0, -10, 1'b1, 1'b1, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, 10));
		plan.push_back(plan_row(STEP_SEARCH, 0, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, 11, 1'b1, 1'b0, 0));
		plan.push_back(plan_row(STEP_SEARCH, 0, -11, 1'b1, 1'b0, 0));
		// duplicate keys
		plan.push_back(plan_row(STEP_WRITE, 1, -10));
		plan.push_back(plan_row(STEP_SEARCH, 0, -10));

		foreach (plan[k]) begin
			case (plan[k].kind)
				STEP_WRITE: send_beat(make_beat(FUNC_WRITE, plan[k].idx, plan[k].val), 1'b0, '0);
				STEP_SEARCH: begin
					send_beat(make_beat(FUNC_SEARCH, $urandom_range(0, TABLE_DEPTH - 1),
						plan[k].val), plan[k].typed, plan[k].want);
				end
				STEP_COUNT: begin
					settle();
					write_count(CNT_W'(plan[k].val));
				end
			endcase
		end
		written_prefix = 2;

		foreach (COUNT_PLAN[p]) begin
			settle();
			pace = pace_e'(p % 4);
			write_count(COUNT_PLAN[p]);
			if (p == 4)
				hold_requests++;

			// lay down an ascending ramp over the span; small spans are rewritten fresh
			for (i = (covered <= 64) ? 0 : written_prefix; i < covered; i++) begin
				ramp = LOW_END + longint'(i) * 64'sd4194304 + longint'($urandom_range(0, 4194303));
				if (i == 0 && $urandom_range(0, 3) == 0)
					ramp = LOW_END;
				else if (i == TABLE_DEPTH - 1 && $urandom_range(0, 3) == 0)
					ramp = HIGH_END;
				else if (i > 0 && $urandom_range(0, 9) == 0)
					ramp = longint'(entry_copy[i - 1]);
				send_beat(make_beat(FUNC_WRITE, i, ramp[KEY_W-1:0]), 1'b0, '0);
			end
			if (covered > written_prefix)
				written_prefix = covered;

			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				j = $urandom_range(0, covered - 1);
				if (r < 70) begin
					s = $urandom_range(0, 99);
					if (s < 55)
						v = entry_copy[j];
					else if (s < 70)
						v = $urandom_range(0, 1) ? entry_copy[j] + 1 : entry_copy[j] - 1;
					else if (s < 80)
						v = $urandom_range(0, 1) ? entry_copy[0] - 1 : entry_copy[covered - 1] + 1;
					else if (s < 95)
						v = $urandom();
					else
						v = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
					send_beat(make_beat(FUNC_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), v),
						1'b0, '0);
				end else if (r < 90) begin
					// keep the table ordered: pick a value between the neighbors
					lo_l = (j == 0) ? LOW_END : longint'(entry_copy[j - 1]);
					hi_l = (j + 1 >= written_prefix) ? HIGH_END : longint'(entry_copy[j + 1]);
					if (hi_l < lo_l) begin
						ramp = lo_l;
					end else begin
						width = longint'(hi_l - lo_l) + 1;
						ramp = lo_l + longint'({$urandom(), $urandom()} % width);
					end
					send_beat(make_beat(FUNC_WRITE, j, ramp[KEY_W-1:0]), 1'b0, '0);
				end else begin
					send_beat(make_beat(FUNC_WRITE, $urandom_range(0, TABLE_DEPTH - 1), $urandom()),
						1'b0, '0);
				end
			end
		end

		pace = PACE_STEADY;
		settle();
		if (bad_beats == 0)
			$display("tb_sorted_table_binary_search_top: PASS");
		else
			$display("tb_sorted_table_binary_search_top: FAIL");
		$finish;
	end

endmodule
